/* hdl/sha1_pkg.sv */
// shared types, constants and round functions of the sha-1 engine
`default_nettype none

package sha1_pkg;

  localparam int CHAIN_WORDS = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int CH_AW       = 3;
  localparam int BUF_AW      = 4;
  localparam int CNT_W       = 7;

  localparam logic [CNT_W-1:0] CNT_LOAD_LAST   = 7'd16;
  localparam logic [CNT_W-1:0] CNT_CHAIN_WORDS = 7'd5;
  localparam logic [CNT_W-1:0] CNT_ROUND_LAST  = 7'd79;
  localparam logic [CNT_W-1:0] CNT_LEN_LAST    = 7'd7;
  localparam logic [CNT_W-1:0] CNT_WORD_LAST   = 7'd4;
  localparam logic [2:0]       LAST_WORD_IDX   = 3'd4;
  localparam logic [5:0]       FILL_LAST       = 6'd63;
  localparam logic [5:0]       FILL_LEN_START  = 6'd56;
  localparam logic [7:0]       PAD_MARK        = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } sha1_state_t;

  // controls from the sequencer to the round datapath
  typedef struct packed {
    logic             load_sched;
    logic             load_hash;
    logic             run_round;
    logic [CNT_W-1:0] round;
  } sha1_core_ctl_t;

  function automatic logic [31:0] sha1_init_word(input logic [CH_AW-1:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hc3d2e1f0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sha1_k(input logic [CNT_W-1:0] t);
    logic [31:0] k;
    priority if (t < 7'd20) k = 32'h5a827999;
    else if (t < 7'd40)     k = 32'h6ed9eba1;
    else if (t < 7'd60)     k = 32'h8f1bbcdc;
    else                    k = 32'hca62c1d6;
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(input logic [CNT_W-1:0] t,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    priority if (t < 7'd20) f = (b & c) | (~b & d);
    else if (t < 7'd40)     f = b ^ c ^ d;
    else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
    else                    f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

/* hdl/sha1_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hdl/sha1_core.sv */
// sha-1 round datapath: message schedule window and working variables
`default_nettype none

module sha1_core
  import sha1_pkg::*;
(
  input  wire logic           clk,
  input  wire sha1_core_ctl_t ctl,
  input  wire logic [31:0]    buf_word,
  input  wire logic [31:0]    chain_word,
  output logic      [31:0]    hash_a
);

  logic [31:0] w_r   [BLOCK_WORDS];
  logic [31:0] w_nxt [BLOCK_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] round_sum;

  // next schedule word and round sum
  always_comb begin
    w_mix     = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new     = {w_mix[30:0], w_mix[31]};
    round_sum = {a_r[26:0], a_r[31:27]} + sha1_f(ctl.round, b_r, c_r, d_r)
              + e_r + sha1_k(ctl.round) + w_r[0];
  end

  // schedule window shifts on load and on every round
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctl.load_sched || ctl.run_round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[BLOCK_WORDS-1] = ctl.load_sched ? buf_word : w_new;
    end
  end

  // working variables: shift chain for load and update, round on run_round, hold otherwise
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.load_hash) begin
      a_nxt = b_r;
      b_nxt = c_r;
      c_nxt = d_r;
      d_nxt = e_r;
      e_nxt = chain_word;
    end else if (ctl.run_round) begin
      a_nxt = round_sum;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  assign hash_a = a_r;

endmodule

`default_nettype wire

/* hdl/sha1_hash_engine.sv */
// sha-1 hash engine top level: byte intake, padding, block sequencer, digest out
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | data_byte, byte_present, end_of_message
//  out_    | output    | out_valid / out_ready | digest_word, word_index, last_word
//
// a byte beat is taken while idle; a full block then passes through the block
// sequencer (buffer and chain reads, the rounds, chain read-modify-writes),
// served by the single round unit and the one read port of each ram.
// a finishing beat then writes the padding and length bytes, runs one block or two,
// and emits the digest beats in turn. in_ready is high only while idle.
// synchronous active-low reset; chain words read as the initial constants
// until written, so no clearing pass is needed. out_ready low holds the digest beat.
`default_nettype none

module sha1_hash_engine
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_digest_word,
  output logic      [2:0]  out_word_index,
  output logic             out_last_word
);

  sha1_state_t state_r, state_nxt;
  sha1_state_t ret_r, ret_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [60:0]      msg_r, msg_nxt;
  logic [60:0]      msg_inc;
  logic [63:0]      len_r, len_nxt;
  logic [23:0]      word_r, word_nxt;
  logic [CHAIN_WORDS-1:0] cvalid_r, cvalid_nxt;
  logic             ch_rvalid_r;
  logic [CH_AW-1:0] ch_raddr_q_r;
  logic [31:0]      out_word_r, out_word_nxt;
  logic [2:0]       out_idx_r, out_idx_nxt;

  logic             put_en;
  logic [7:0]       put_byte;
  logic             buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  logic [31:0]      buf_wdata;
  logic [BUF_AW-1:0] buf_raddr;
  logic [31:0]      buf_rdata;
  logic             ch_we;
  logic [CH_AW-1:0] ch_raddr;
  logic [31:0]      ch_wdata;
  logic [31:0]      ch_rdata;
  logic [31:0]      chain_rd;
  logic [31:0]      hash_a;
  sha1_core_ctl_t   core_ctl;

  // block buffer, one 32-bit big-endian word per entry
  sha1_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // chaining words
  sha1_ram #(.WIDTH(32), .DEPTH(CHAIN_WORDS)) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_raddr_q_r),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  sha1_core u_core (
    .clk        (clk),
    .ctl        (core_ctl),
    .buf_word   (buf_rdata),
    .chain_word (chain_rd),
    .hash_a     (hash_a)
  );

  // unwritten chain entries read as the initial constants
  assign chain_rd = ch_rvalid_r ? ch_rdata : sha1_init_word(ch_raddr_q_r);
  assign msg_inc  = msg_r + 61'(in_byte_present);
  assign ch_wdata = chain_rd + hash_a;

  // sequencer: next state and controls
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    cnt_nxt      = cnt_r;
    msg_nxt      = msg_r;
    len_nxt      = len_r;
    cvalid_nxt   = cvalid_r;
    out_word_nxt = out_word_r;
    out_idx_nxt  = out_idx_r;
    put_en       = 1'b0;
    put_byte     = 8'h00;
    buf_raddr    = '0;
    ch_raddr     = '0;
    ch_we        = 1'b0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    core_ctl     = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            msg_nxt  = msg_inc;
            put_en   = 1'b1;
            put_byte = in_data_byte;
          end
          if (in_end_of_message) begin
            len_nxt = {msg_inc, 3'b000};
          end
          if (in_byte_present && fill_r == FILL_LAST) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            ret_nxt   = in_end_of_message ? ST_PAD80 : ST_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end

      ST_PAD80: begin
        put_en   = 1'b1;
        put_byte = PAD_MARK;
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end

      ST_PADZ: begin
        if (fill_r == FILL_LEN_START) begin
          state_nxt = ST_PADLEN;
          cnt_nxt   = '0;
        end else begin
          put_en = 1'b1;
          if (fill_r == FILL_LAST) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            ret_nxt   = ST_PADZ;
          end
        end
      end

      ST_PADLEN: begin
        put_en   = 1'b1;
        put_byte = len_r[63:56];
        len_nxt  = {len_r[55:0], 8'h00};
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == CNT_LEN_LAST) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          ret_nxt   = ST_EMIT_RD;
        end
      end

      // stream buffer words into the schedule and chain words into a..e
      ST_LOAD: begin
        if (cnt_r < CNT_LOAD_LAST) begin
          buf_raddr = cnt_r[BUF_AW-1:0];
        end
        if (cnt_r < CNT_CHAIN_WORDS) begin
          ch_raddr = cnt_r[CH_AW-1:0];
        end
        core_ctl.load_sched = (cnt_r != '0);
        core_ctl.load_hash  = (cnt_r != '0) && (cnt_r <= CNT_CHAIN_WORDS);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == CNT_LOAD_LAST) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end
      end

      ST_ROUND: begin
        core_ctl.run_round = 1'b1;
        core_ctl.round     = cnt_r;
        cnt_nxt            = cnt_r + 7'd1;
        if (cnt_r == CNT_ROUND_LAST) begin
          state_nxt = ST_UPDATE;
          cnt_nxt   = '0;
        end
      end

      // read chain word k while writing back word k-1
      ST_UPDATE: begin
        if (cnt_r < CNT_CHAIN_WORDS) begin
          ch_raddr = cnt_r[CH_AW-1:0];
        end
        if (cnt_r != '0) begin
          ch_we                    = 1'b1;
          cvalid_nxt[ch_raddr_q_r] = 1'b1;
          core_ctl.load_hash       = 1'b1;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == CNT_CHAIN_WORDS) begin
          state_nxt = ret_r;
          cnt_nxt   = '0;
        end
      end

      ST_EMIT_RD: begin
        ch_raddr  = cnt_r[CH_AW-1:0];
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_word_nxt = chain_rd;
        out_idx_nxt  = cnt_r[2:0];
        state_nxt    = ST_EMIT_HOLD;
      end

      ST_EMIT_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (cnt_r == CNT_WORD_LAST) begin
            cvalid_nxt = '0;
            msg_nxt    = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 7'd1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // byte packing into buffer words
  always_comb begin
    word_nxt  = word_r;
    fill_nxt  = fill_r;
    buf_we    = 1'b0;
    buf_waddr = fill_r[5:2];
    buf_wdata = {word_r, put_byte};
    if (put_en) begin
      word_nxt = {word_r[15:0], put_byte};
      fill_nxt = fill_r + 6'd1;
      buf_we   = (fill_r[1:0] == 2'b11);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      cnt_r    <= '0;
      fill_r   <= '0;
      msg_r    <= '0;
      cvalid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      msg_r    <= msg_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    word_r       <= word_nxt;
    out_word_r   <= out_word_nxt;
    out_idx_r    <= out_idx_nxt;
    ch_raddr_q_r <= ch_raddr;
    ch_rvalid_r  <= cvalid_r[ch_raddr];
  end

  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == LAST_WORD_IDX);

endmodule

`default_nettype wire

/* tb/sv/tb_sha1_hash_engine.sv */
// self-checking testbench for the sha-1 hash engine: byte beats in, digest words checked
`default_nettype none

module tb_sha1_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HASH_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [7:0] PAD_MARKER    = 8'h80;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;
  localparam logic [2:0] FINAL_WORD    = 3'd4;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         LONG_HOLD     = 600;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // running hash state of the predictor
  logic [31:0] hv_words [5];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  digest_beat_t pending_digest [$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_left = 0;

  sha1_hash_engine u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the engine hangs
  initial begin
    #3ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_hash_state();
    for (int i = 0; i < 5; i++) hv_words[i] = HASH_INIT[i];
    block_fill = '0;
    msg_len = '0;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 80-round compression of the buffered block into the chaining words
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hv_words[0]; b = hv_words[1]; c = hv_words[2]; d = hv_words[3]; e = hv_words[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);          k = 32'h5a827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;                   k = 32'h6ed9eba1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;                   k = 32'hca62c1d6;
      end
      tmp = rol(a, 5) + f + e + k + w[t];
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    hv_words[0] += a; hv_words[1] += b; hv_words[2] += c;
    hv_words[3] += d; hv_words[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    msg_block[block_fill] = v;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endfunction

  // pad, append the bit length and queue the five digest words
  function automatic void close_message();
    logic [63:0] bit_len;
    bit_len = {msg_len, 3'b000};
    absorb_byte(PAD_MARKER);
    while (block_fill != LEN_FIELD_POS) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
    for (int i = 0; i < 5; i++)
      pending_digest.push_back('{hv_words[i], 3'(i), 3'(i) == FINAL_WORD});
    clear_hash_state();
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // digest beat checker
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest.size() == 0) begin
        note_failure("unexpected digest beat", 32'h0, out_digest_word);
      end else begin
        exp_beat = pending_digest.pop_front();
        if (exp_beat.word !== out_digest_word)
          note_failure("digest_word", exp_beat.word, out_digest_word);
        if (exp_beat.idx !== out_word_index)
          note_failure("word_index", 32'(exp_beat.idx), 32'(out_word_index));
        if (exp_beat.last !== out_last_word)
          note_failure("last_word", 32'(exp_beat.last), 32'(out_last_word));
      end
    end
  end

  // offer one input beat, wait for acceptance, update the predictor
  task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    if (present) begin
      msg_len = msg_len + 61'd1;
      absorb_byte(b);
    end
    if (eom) close_message();
  endtask

  task automatic wait_digests_drained();
    in_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one message of random bytes, closed on the last byte or by a bare end beat
  task automatic send_message(input int len, output int beats);
    logic end_on_last;
    end_on_last = (len != 0) && ($urandom_range(1) == 1);
    beats = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, end_on_last && (i == len - 1));
      beats++;
    end
    if (!end_on_last) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      beats++;
    end
  endtask

  // empty message, stray beats, short known messages, end with and without a byte
  task automatic test_directed_cases();
    set_idling(0, 0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'h3c, 1'b0, 1'b1);
    send_beat(8'h80, 1'b1, 1'b1);
    wait_digests_drained();
  endtask

  // mostly short messages, some at the padding and block boundaries
  task automatic test_random_messages(input int item_budget, input int send_pct,
                                      input int recv_pct);
    int sent;
    int len;
    int beats;
    int pick;
    int edge_lens [5];
    edge_lens = '{55, 56, 63, 64, 65};
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(12);
      else if (pick < 88) len = $urandom_range(40, 13);
      else len = edge_lens[$urandom_range(4)];
      send_message(len, beats);
      sent += beats;
    end
    wait_digests_drained();
  endtask

  // receiver holds off long enough that the engine stalls its input
  task automatic test_output_backpressure();
    int beats;
    set_idling(0, 20);
    hold_left <= LONG_HOLD;
    send_message(5, beats);
    send_message(0, beats);
    send_message(9, beats);
    wait_digests_drained();
  endtask

  initial begin
    clear_hash_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_messages(50, 6, 79);
    test_output_backpressure();
    test_random_messages(50, 79, 6);
    test_random_messages(50, 0, 0);
    wait_digests_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sha1_hash_engine.f */
hdl/sha1_pkg.sv
hdl/sha1_ram.sv
hdl/sha1_core.sv
hdl/sha1_hash_engine.sv
tb/sv/tb_sha1_hash_engine.sv
